// ----- rtl/skc_pkg.sv -----
// shared types and constants for the solenoid kick sequencer
package skc_pkg;

    localparam int unsigned SKC_LEVELS = 16;

    localparam logic [2:0] OP_UPDATE       = 3'd0;
    localparam logic [2:0] OP_STRAIGHT_LVL = 3'd1;
    localparam logic [2:0] OP_CHIP_LVL     = 3'd2;
    localparam logic [2:0] OP_STRAIGHT_W   = 3'd3;
    localparam logic [2:0] OP_CHIP_W       = 3'd4;
    localparam logic [2:0] OP_TICK         = 3'd5;

    localparam logic [1:0] PH_CHARGE = 2'd0;
    localparam logic [1:0] PH_READY  = 2'd1;
    localparam logic [1:0] PH_SELECT = 2'd2;
    localparam logic [1:0] PH_KICK   = 2'd3;

    localparam logic [1:0] CFG_SELECT_WAIT   = 2'd0;
    localparam logic [1:0] CFG_STRAIGHT_STEP = 2'd1;
    localparam logic [1:0] CFG_CHIP_STEP     = 2'd2;

    localparam logic [7:0]  SELECT_WAIT_RST   = 8'd5;
    localparam logic [11:0] STRAIGHT_STEP_RST = 12'd200;
    localparam logic [11:0] CHIP_STEP_RST     = 12'd100;

    localparam logic [15:0] PULSE_START = 16'hFFF0;
    localparam logic [15:0] WIDTH_MAX   = 16'hFFFF;

    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 8;

    typedef struct packed {
        logic        charge_done_n;
        logic [15:0] width_direct;
        logic [4:0]  power_level;
        logic [2:0]  opcode;
    } skc_item_t;

    typedef struct packed {
        logic       kick_accepted;
        logic       kick_pulse;
        logic       chip_mode;
        logic       boost_on;
        logic [1:0] phase;
    } skc_result_t;

    typedef struct packed {
        logic [7:0]  select_wait;
        logic [11:0] straight_step;
        logic [11:0] chip_step;
    } skc_cfg_t;

endpackage

// ----- rtl/solenoid_kick_sequencer.sv -----
// top level of the solenoid kick sequencer
//
// words in on the s_ stream: update steps, kick requests and timer ticks.
// one result word out on the m_ stream per input word, giving phase, boost
// enable, mode pin, drive pulse level and whether a kick request was taken.
// registers are written over the cfg_ channel, which is always ready;
// index 0 select_wait, 1 straight_step, 2 chip_step, other indexes ignored.
// a word accepted into the input register is processed when the result register
// can take it, and its result is then offered from the result register.
// throughput: one word per cycle while the receiver keeps taking results; the phase
// state and the result register are both updated when a word is processed.
// reset: charging phase, boost off, chip mode, counters and width zero,
// registers back to their defaults, both stages empty.
// a stalled receiver holds the result register; the input register takes one
// more word, then s_tready drops until the result is taken.
module solenoid_kick_sequencer
    import skc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // opcode[2:0], power_level[7:3], width_direct[23:8], charge_done_n[24]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // phase[1:0], boost_on[2], chip_mode[3], kick_pulse[4], kick_accepted[5]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [11:0]           cfg_data
);

    skc_cfg_t    cfg;
    skc_item_t   item;
    skc_result_t result;
    logic        item_valid;
    logic        advance;
    logic        fire;
    logic        out_valid_reg;
    logic        out_valid_next;
    skc_result_t out_data_reg;

    assign cfg_ready = 1'b1;

    skc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    skc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    assign advance = !out_valid_reg || m_tready;
    assign fire    = item_valid && advance;

    skc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - $bits(skc_result_t))'(0), out_data_reg};

endmodule

// ----- rtl/skc_cfg_regs.sv -----
// configuration register bank
module skc_cfg_regs
    import skc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [11:0] wr_data,
    output skc_cfg_t    cfg
);

    skc_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.select_wait   <= SELECT_WAIT_RST;
            cfg_reg.straight_step <= STRAIGHT_STEP_RST;
            cfg_reg.chip_step     <= CHIP_STEP_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_SELECT_WAIT:   cfg_reg.select_wait   <= wr_data[7:0];
                CFG_STRAIGHT_STEP: cfg_reg.straight_step <= wr_data;
                CFG_CHIP_STEP:     cfg_reg.chip_step     <= wr_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/skc_in_stage.sv -----
// input register: unpacks and holds one accepted word
module skc_in_stage
    import skc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 advance,
    output logic                 item_valid,
    output skc_item_t            item
);

    logic      valid_reg;
    logic      valid_next;
    skc_item_t item_reg;

    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= s_tdata[$bits(skc_item_t)-1:0];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/skc_core.sv -----
// kicker phase state and per-word next-state logic
module skc_core
    import skc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  skc_item_t   item,
    input  skc_cfg_t    cfg,
    output skc_result_t result
);

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [7:0]  wait_reg;
    logic [7:0]  wait_next;
    logic [15:0] pcount_reg;
    logic [15:0] pcount_next;
    logic [15:0] pwidth_reg;
    logic [15:0] pwidth_next;
    logic        mode_reg;
    logic        mode_next;
    logic        boost_reg;
    logic        boost_next;

    logic        kick_req;
    logic        kick_chip;
    logic [15:0] kick_width;
    logic        kick_take;
    logic [11:0] step;
    logic [16:0] product;
    logic [15:0] level_width;
    logic        level_ok;

    assign kick_chip = (item.opcode == OP_CHIP_LVL) || (item.opcode == OP_CHIP_W);
    assign step      = kick_chip ? cfg.chip_step : cfg.straight_step;
    assign product   = 17'(item.power_level) * 17'(step);
    assign level_width = product[16] ? WIDTH_MAX : product[15:0];
    assign level_ok  = 32'(item.power_level) < 32'(SKC_LEVELS);

    always_comb
    begin
        kick_req   = 1'b0;
        kick_width = item.width_direct;
        case (item.opcode)
            OP_STRAIGHT_LVL, OP_CHIP_LVL:
            begin
                kick_req   = level_ok;
                kick_width = level_width;
            end
            OP_STRAIGHT_W, OP_CHIP_W:
            begin
                kick_req = 1'b1;
            end
            default:
            begin
                kick_req = 1'b0;
            end
        endcase
    end

    assign kick_take = kick_req && (phase_reg == PH_READY);

    always_comb
    begin
        phase_next  = phase_reg;
        wait_next   = wait_reg;
        pcount_next = pcount_reg;
        pwidth_next = pwidth_reg;
        mode_next   = mode_reg;
        boost_next  = boost_reg;
        if (kick_take)
        begin
            mode_next   = kick_chip;
            boost_next  = 1'b0;
            pwidth_next = kick_width;
            wait_next   = 8'd0;
            phase_next  = PH_SELECT;
        end
        else if (item.opcode == OP_TICK)
        begin
            pcount_next = pcount_reg + 16'd1;
        end
        else if (item.opcode == OP_UPDATE)
        begin
            case (phase_reg)
                PH_CHARGE:
                begin
                    mode_next  = 1'b1;
                    boost_next = 1'b1;
                    if (!item.charge_done_n)
                    begin
                        phase_next = PH_READY;
                    end
                end
                PH_READY:
                begin
                    boost_next = 1'b0;
                end
                PH_SELECT:
                begin
                    if (wait_reg >= cfg.select_wait)
                    begin
                        pcount_next = PULSE_START;
                        phase_next  = PH_KICK;
                    end
                    wait_next = wait_reg + 8'd1;
                end
                default:
                begin
                    boost_next = 1'b0;
                    if (pcount_reg < PULSE_START && pcount_reg > pwidth_reg)
                    begin
                        phase_next = PH_CHARGE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_CHARGE;
            wait_reg   <= 8'd0;
            pcount_reg <= 16'd0;
            pwidth_reg <= 16'd0;
            mode_reg   <= 1'b1;
            boost_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            wait_reg   <= wait_next;
            pcount_reg <= pcount_next;
            pwidth_reg <= pwidth_next;
            mode_reg   <= mode_next;
            boost_reg  <= boost_next;
        end
    end

    assign result.phase         = phase_next;
    assign result.boost_on      = boost_next;
    assign result.chip_mode     = mode_next;
    assign result.kick_pulse    = (phase_next == PH_KICK) && (pcount_next < pwidth_next);
    assign result.kick_accepted = kick_take;

endmodule

// ----- rtl/skc_checker.sv -----
// port-level checks for the solenoid kick sequencer, bound to the top level
module skc_checker
    import skc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // no result word offered while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result offered during reset");

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // drive pulse only in the kicking phase
    a_pulse_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[1:0] == PH_KICK)
        else $error("kick pulse outside kicking phase");

    // a taken kick leaves the block selecting with boost off
    a_accept_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5] |-> m_tdata[1:0] == PH_SELECT && !m_tdata[2])
        else $error("accepted kick without selecting phase");

endmodule

bind solenoid_kick_sequencer skc_checker u_skc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/skc_kick_checker.sv -----
// checker for the solenoid kick sequencer: mirrors its state and compares every result word
module skc_kick_checker
    import skc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // opcode[2:0], power_level[7:3], width_direct[23:8], charge_done_n[24]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // phase[1:0], boost_on[2], chip_mode[3], kick_pulse[4], kick_accepted[5]
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [11:0]           cfg_data,
    output int unsigned           errors,
    output int unsigned           pending
);

    skc_cfg_t    regs;
    logic [1:0]  cur_phase;
    logic [7:0]  wait_count;
    logic [15:0] pulse_count;
    logic [15:0] pulse_width;
    logic        mode_latch;
    logic        boost_latch;
    skc_result_t kick_results_due[$];

    task automatic take_kick(input logic chip, input logic [15:0] width, output logic taken);
        taken = 1'b0;
        if (cur_phase == PH_READY)
        begin
            mode_latch  = chip;
            boost_latch = 1'b0;
            pulse_width = width;
            wait_count  = 8'd0;
            cur_phase   = PH_SELECT;
            taken       = 1'b1;
        end
    endtask

    task automatic step_sequencer(input skc_item_t w, output skc_result_t r);
        logic        taken;
        logic [31:0] product;
        taken = 1'b0;
        case (w.opcode)
            OP_UPDATE:
            begin
                case (cur_phase)
                    PH_CHARGE:
                    begin
                        mode_latch  = 1'b1;
                        boost_latch = 1'b1;
                        if (!w.charge_done_n)
                            cur_phase = PH_READY;
                    end
                    PH_READY:
                        boost_latch = 1'b0;
                    PH_SELECT:
                    begin
                        if (wait_count >= regs.select_wait)
                        begin
                            pulse_count = PULSE_START;
                            cur_phase   = PH_KICK;
                        end
                        wait_count = wait_count + 8'd1;
                    end
                    default:
                    begin
                        boost_latch = 1'b0;
                        if (pulse_count < PULSE_START && pulse_count > pulse_width)
                            cur_phase = PH_CHARGE;
                    end
                endcase
            end
            OP_STRAIGHT_LVL, OP_CHIP_LVL:
            begin
                if (w.power_level < SKC_LEVELS)
                begin
                    product = (w.opcode == OP_CHIP_LVL) ? 32'(regs.chip_step)
                                                        : 32'(regs.straight_step);
                    product = product * 32'(w.power_level);
                    if (product > WIDTH_MAX)
                        product = WIDTH_MAX;
                    take_kick(w.opcode == OP_CHIP_LVL, product[15:0], taken);
                end
            end
            OP_STRAIGHT_W:
                take_kick(1'b0, w.width_direct, taken);
            OP_CHIP_W:
                take_kick(1'b1, w.width_direct, taken);
            OP_TICK:
                pulse_count = pulse_count + 16'd1;
            default:
                ;
        endcase
        r.phase         = cur_phase;
        r.boost_on      = boost_latch;
        r.chip_mode     = mode_latch;
        r.kick_pulse    = (cur_phase == PH_KICK) && (pulse_count < pulse_width);
        r.kick_accepted = taken;
    endtask

    function automatic int unsigned field_differs(input string name, input int unsigned want,
                                                  input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        skc_result_t predicted;
        skc_result_t got;
        if (!rst_n)
        begin
            regs.select_wait   = SELECT_WAIT_RST;
            regs.straight_step = STRAIGHT_STEP_RST;
            regs.chip_step     = CHIP_STEP_RST;
            cur_phase   = PH_CHARGE;
            wait_count  = 8'd0;
            pulse_count = 16'd0;
            pulse_width = 16'd0;
            mode_latch  = 1'b1;
            boost_latch = 1'b0;
            kick_results_due.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(skc_result_t)-1:0];
                if (kick_results_due.size() == 0)
                begin
                    $display("%0t: result word expected none got %h", $time, m_tdata);
                    errors = errors + 1;
                end
                else
                begin
                    predicted = kick_results_due.pop_front();
                    errors = errors
                        + field_differs("phase", 32'(predicted.phase), 32'(got.phase))
                        + field_differs("boost_on", 32'(predicted.boost_on),
                                        32'(got.boost_on))
                        + field_differs("chip_mode", 32'(predicted.chip_mode),
                                        32'(got.chip_mode))
                        + field_differs("kick_pulse", 32'(predicted.kick_pulse),
                                        32'(got.kick_pulse))
                        + field_differs("kick_accepted", 32'(predicted.kick_accepted),
                                        32'(got.kick_accepted))
                        + field_differs("padding", 0,
                                        32'(m_tdata[OUT_DATA_W-1:$bits(skc_result_t)]));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SELECT_WAIT:   regs.select_wait   = cfg_data[7:0];
                    CFG_STRAIGHT_STEP: regs.straight_step = cfg_data;
                    CFG_CHIP_STEP:     regs.chip_step     = cfg_data;
                    default:           ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                step_sequencer(s_tdata[$bits(skc_item_t)-1:0], predicted);
                kick_results_due.push_back(predicted);
            end
            pending = kick_results_due.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// testbench top for the solenoid kick sequencer: reset, stimulus and verdict
module tb;
    import skc_pkg::*;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [11:0]           cfg_data;
    int unsigned           errors;
    int unsigned           pending;

    logic        calm;
    logic        noisy;
    int unsigned sent;
    logic [7:0]  wait_steps;
    logic [11:0] straight_step;
    logic [11:0] chip_step;

    solenoid_kick_sequencer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    skc_kick_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= 10);

    task automatic send_word(input logic [2:0] op, input logic [4:0] level,
                             input logic [15:0] wd, input logic done_n);
        skc_item_t w;
        w.opcode        = op;
        w.power_level   = level;
        w.width_direct  = wd;
        w.charge_done_n = done_n;
        while (!calm && $urandom_range(0, 99) < 10)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - $bits(skc_item_t)){1'b0}}, w};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        sent = sent + 1;
    endtask

    // occasionally slips a stray word in ahead of the intended one
    task automatic put(input logic [2:0] op, input logic [4:0] level,
                       input logic [15:0] wd, input logic done_n);
        logic [2:0]  stray_op;
        logic [4:0]  stray_lvl;
        logic [15:0] stray_wd;
        if (noisy && $urandom_range(0, 99) < 5)
        begin
            stray_op  = 3'($urandom_range(0, 7));
            stray_lvl = 5'($urandom_range(0, 31));
            stray_wd  = 16'($urandom_range(0, 65535));
            if (stray_op == OP_STRAIGHT_W || stray_op == OP_CHIP_W)
                stray_wd = 16'($urandom_range(0, 300));
            // keep stray pulses short
            if ((stray_op == OP_STRAIGHT_LVL || stray_op == OP_CHIP_LVL)
                && stray_lvl < SKC_LEVELS)
                stray_lvl = 5'd0;
            send_word(stray_op, stray_lvl, stray_wd, 1'($urandom_range(0, 1)));
        end
        send_word(op, level, wd, done_n);
    endtask

    // charge, request, select wait, pulse out and back to charging
    task automatic run_kick(input logic [2:0] op, input logic [4:0] level,
                            input logic [15:0] wd, input logic poke);
        logic [31:0] span;
        span = 32'(wd);
        if (op == OP_STRAIGHT_LVL || op == OP_CHIP_LVL)
        begin
            span = (op == OP_CHIP_LVL) ? 32'(chip_step) : 32'(straight_step);
            span = (level < SKC_LEVELS) ? span * 32'(level) : 0;
        end
        put(OP_UPDATE, 5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)),
            1'($urandom_range(0, 1)));
        put(OP_UPDATE, 5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)), 1'b0);
        put(op, level, wd, 1'($urandom_range(0, 1)));
        if (poke)
            put(3'(OP_STRAIGHT_LVL + $urandom_range(0, 3)), 5'($urandom_range(0, 15)),
                16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        repeat (int'(wait_steps) + 2)
            put(OP_UPDATE, 5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)),
                1'($urandom_range(0, 1)));
        repeat (span + 17)
            put(OP_TICK, 5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)),
                1'($urandom_range(0, 1)));
        put(OP_UPDATE, 5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)),
            1'($urandom_range(0, 1)));
    endtask

    task automatic random_kicks(input int unsigned count);
        int unsigned start;
        int unsigned top_level;
        logic [2:0]  op;
        logic [4:0]  level;
        logic [15:0] wd;
        logic [11:0] step;
        start = sent;
        while (sent - start < count)
        begin
            op = 3'(OP_STRAIGHT_LVL + $urandom_range(0, 3));
            step = (op == OP_CHIP_LVL) ? chip_step : straight_step;
            top_level = (step == 0) ? 15 : 400 / step;
            if (top_level > 15)
                top_level = 15;
            level = 5'($urandom_range(0, top_level));
            if ($urandom_range(0, 19) == 0)
                level = 5'($urandom_range(16, 31));
            if (op == OP_STRAIGHT_LVL || op == OP_CHIP_LVL)
                wd = 16'($urandom_range(0, 65535));
            else
                wd = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 600))
                                                 : 16'($urandom_range(0, 60));
            run_kick(op, level, wd, $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        case (idx)
            CFG_SELECT_WAIT:   wait_steps    = val[7:0];
            CFG_STRAIGHT_STEP: straight_step = val;
            CFG_CHIP_STEP:     chip_step     = val;
            default:           ;
        endcase
    endtask

    // only written once the block has drained
    task automatic set_regs(input logic [11:0] sel, input logic [11:0] st,
                            input logic [11:0] ch);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
        write_reg(CFG_SELECT_WAIT, sel);
        write_reg(CFG_STRAIGHT_STEP, st);
        write_reg(CFG_CHIP_STEP, ch);
        write_reg(CFG_UNUSED, 12'($urandom_range(0, 4095)));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b1;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SELECT_WAIT;
        cfg_data  = 12'd0;
        calm      = 1'b0;
        noisy     = 1'b0;
        sent      = 0;
        wait_steps    = SELECT_WAIT_RST;
        straight_step = STRAIGHT_STEP_RST;
        chip_step     = CHIP_STEP_RST;
        #1 rst_n = 1'b0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, register defaults
        put(OP_UPDATE, 5'd0, 16'd0, 1'b1);
        put(OP_STRAIGHT_LVL, 5'd3, 16'd0, 1'b0);
        put(OP_CHIP_W, 5'd0, 16'd100, 1'b0);
        put(OP_SPARE_A, 5'd31, 16'hFFFF, 1'b1);
        put(OP_SPARE_B, 5'd0, 16'd0, 1'b0);
        put(OP_TICK, 5'd31, 16'hFFFF, 1'b1);
        put(OP_UPDATE, 5'd0, 16'd0, 1'b0);
        put(OP_UPDATE, 5'd0, 16'd0, 1'b1);
        put(OP_STRAIGHT_LVL, 5'd16, 16'd0, 1'b0);
        put(OP_CHIP_LVL, 5'd31, 16'd0, 1'b0);
        put(OP_SPARE_B, 5'd31, 16'hFFFF, 1'b1);
        put(OP_TICK, 5'd0, 16'd0, 1'b0);
        run_kick(OP_STRAIGHT_LVL, 5'd0, 16'hFFFF, 1'b0);
        run_kick(OP_CHIP_LVL, 5'd1, 16'd0, 1'b1);
        run_kick(OP_STRAIGHT_W, 5'd31, 16'd1, 1'b1);
        run_kick(OP_CHIP_W, 5'd0, 16'd0, 1'b0);
        noisy = 1'b1;
        random_kicks(150);

        // zero wait, zero straight step; top level pulse, no idling
        set_regs(12'hF00, 12'd0, 12'd16);
        calm = 1'b1;
        run_kick(OP_CHIP_LVL, 5'd15, 16'd0, 1'b0);
        run_kick(OP_STRAIGHT_LVL, 5'd15, 16'hFFFF, 1'b0);
        random_kicks(150);
        calm = 1'b0;

        // longest select wait, wait counter wraps
        set_regs(12'h0FF, 12'hFFF, 12'd0);
        random_kicks(150);

        set_regs({4'($urandom_range(0, 15)), 8'($urandom_range(0, 12))},
                 12'($urandom_range(1, 40)), 12'($urandom_range(1, 40)));
        random_kicks(150);

        // widest direct pulse never ends, so it goes last
        calm  = 1'b1;
        noisy = 1'b0;
        put(OP_UPDATE, 5'd0, 16'd0, 1'b0);
        put(OP_UPDATE, 5'd0, 16'd0, 1'b0);
        put(OP_STRAIGHT_W, 5'd0, 16'hFFFF, 1'b0);
        repeat (int'(wait_steps) + 2)
            put(OP_UPDATE, 5'd0, 16'd0, 1'b1);
        repeat (40)
            put(OP_TICK, 5'd0, 16'd0, 1'b1);
        put(OP_UPDATE, 5'd0, 16'd0, 1'b1);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10)
            @(negedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
